### hw/rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// shared widths, cofactor index table and the saturating clip function for the
// 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int FRAC_BITS = 16;          // fraction bits of every word
    localparam int EW        = 32;          // element / result width
    localparam int PW        = 2 * EW;      // cofactor width, exact
    localparam int DW        = 3 * EW + 2;  // determinant width, exact
    localparam int QB        = EW + 1;      // quotient bits before rounding
    localparam int NW        = PW + 2 * FRAC_BITS;  // dividend width
    localparam int RW        = NW - QB;     // initial partial remainder width
    localparam int AW        = PW - FRAC_BITS + 1;  // rounded adjugate width
    localparam int TW        = DW - 2 * FRAC_BITS + 1;
    localparam int SW        = DW + 2;      // saturator input width
    localparam int TOL_W     = EW - 1;
    localparam int DIV_LAT   = QB + 2;      // divider register count
    localparam int PIPE_LAT  = DIV_LAT + 7; // start to done

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [PW-1:0] cof_t;
    typedef logic [PW-1:0]        pmag_t;
    typedef logic [DW-1:0]        dmag_t;

    typedef struct packed {
        logic [EW-1:0] val;
        logic          clip;
    } sat_t;

    // cofactor k = a[i0]*a[i1] - a[i2]*a[i3], elements in row-major order
    localparam int CF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // clip a magnitude to the signed word range and apply the sign
    function automatic sat_t sat_q(input logic [SW-1:0] mag, input logic neg);
        logic [SW-1:0] lim;
        logic [EW-1:0] v;
        sat_t          r;
        lim    = neg ? (SW'(1) << (EW - 1)) : ((SW'(1) << (EW - 1)) - SW'(1));
        r.clip = mag > lim;
        v      = r.clip ? lim[EW-1:0] : mag[EW-1:0];
        r.val  = neg ? (~v + EW'(1)) : v;
        return r;
    endfunction

endpackage

### hw/rtl/m3i_cofactor.sv
// ----------------------------------------------------------------------------
// m3i_cofactor
// two stages: eighteen element products, then the nine adjugate cofactors
// ----------------------------------------------------------------------------
module m3i_cofactor
    import m3i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  vld_in,
    input  elem_t a [9],
    output logic  vld_out,
    output cof_t  p [9],
    output elem_t row0 [3]
);

    cof_t  prod_reg [9][2];
    cof_t  p_reg [9];
    elem_t row0_s1_reg [3];
    elem_t row0_reg [3];
    logic  vld_s1_reg;
    logic  vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg <= 1'b0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            vld_s1_reg <= vld_in;
            vld_reg    <= vld_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            prod_reg[k][0] <= PW'(a[CF_IDX[k][0]]) * PW'(a[CF_IDX[k][1]]);
            prod_reg[k][1] <= PW'(a[CF_IDX[k][2]]) * PW'(a[CF_IDX[k][3]]);
            p_reg[k]       <= prod_reg[k][0] - prod_reg[k][1];
        end
        for (int j = 0; j < 3; j++)
        begin
            row0_s1_reg[j] <= a[j];
            row0_reg[j]    <= row0_s1_reg[j];
        end
    end

    assign vld_out = vld_reg;
    assign p       = p_reg;
    assign row0    = row0_reg;

endmodule

### hw/rtl/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// four stages: split products, term assembly, three-term sum, magnitude;
// cofactor magnitudes and signs ride alongside
// ----------------------------------------------------------------------------
module m3i_det
    import m3i_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vld_in,
    input  cof_t       p [9],
    input  elem_t      row0 [3],
    output logic       vld_out,
    output pmag_t      pm [9],
    output logic [8:0] pneg,
    output dmag_t      dmag,
    output logic       dneg
);

    logic signed [PW-1:0] hi_reg [3];
    logic signed [PW:0]   lo_reg [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] d_reg;
    dmag_t                dmag_reg;
    logic                 dneg_reg;
    pmag_t                pm_reg [4][9];
    logic [8:0]           pneg_reg [4];
    logic [3:0]           vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        // a0j times cofactor, cut into a signed high half and unsigned low half
        for (int j = 0; j < 3; j++)
        begin
            hi_reg[j] <= PW'(row0[j]) * PW'($signed(p[3*j][PW-1:EW]));
            lo_reg[j] <= (PW+1)'(row0[j]) * (PW+1)'($signed({1'b0, p[3*j][EW-1:0]}));
            term_reg[j] <= (DW'(hi_reg[j]) <<< EW) + DW'(lo_reg[j]);
        end
        d_reg    <= term_reg[0] + term_reg[1] + term_reg[2];
        dneg_reg <= d_reg[DW-1];
        dmag_reg <= d_reg[DW-1] ? DW'(~d_reg + DW'(1)) : DW'(d_reg);

        for (int k = 0; k < 9; k++)
        begin
            pm_reg[0][k]   <= p[k][PW-1] ? PW'(~p[k] + PW'(1)) : PW'(p[k]);
            pneg_reg[0][k] <= p[k][PW-1];
        end
        for (int s = 1; s < 4; s++)
        begin
            pm_reg[s]   <= pm_reg[s-1];
            pneg_reg[s] <= pneg_reg[s-1];
        end
    end

    assign vld_out = vld_reg[3];
    assign pm      = pm_reg[3];
    assign pneg    = pneg_reg[3];
    assign dmag    = dmag_reg;
    assign dneg    = dneg_reg;

endmodule

### hw/rtl/m3i_divider.sv
// ----------------------------------------------------------------------------
// m3i_divider
// pipelined restoring divider: |cofactor| * 2^(2F) / |det|, one quotient bit
// per stage, overflow check up front, round half up at the end
// ----------------------------------------------------------------------------
module m3i_divider
    import m3i_pkg::*;
(
    input  logic        clk,
    input  pmag_t       pm,
    input  dmag_t       dmag,
    output logic [QB:0] q,
    output logic        ovf
);

    logic [NW-1:0] num;
    dmag_t         r_reg [QB+1];
    dmag_t         d_reg [QB+1];
    logic [QB-1:0] n_reg [QB];
    logic [QB-1:0] q_reg [QB+1];
    logic          ovf_reg [QB+1];
    logic [QB:0]   q_out_reg;
    logic          ovf_out_reg;
    logic [DW:0]   rem2;
    logic          round_up;

    assign num = {pm, {(2*FRAC_BITS){1'b0}}};

    // quotient can only reach 2^QB if the top of the dividend already does
    always_ff @(posedge clk)
    begin
        r_reg[0]   <= DW'(num[NW-1:QB]);
        ovf_reg[0] <= DW'(num[NW-1:QB]) >= dmag;
        n_reg[0]   <= num[QB-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= dmag;
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        logic          ge;

        assign trial = {r_reg[k], n_reg[k][QB-1]};
        assign diff  = {1'b0, trial} - {2'b00, d_reg[k]};
        assign ge    = !diff[DW+1];

        always_ff @(posedge clk)
        begin
            r_reg[k+1]   <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
            ovf_reg[k+1] <= ovf_reg[k];
            d_reg[k+1]   <= d_reg[k];
        end

        if (k < QB - 1) begin : g_num
            always_ff @(posedge clk)
            begin
                n_reg[k+1] <= {n_reg[k][QB-2:0], 1'b0};
            end
        end
    end

    assign rem2     = {r_reg[QB], 1'b0};
    assign round_up = rem2 >= {1'b0, d_reg[QB]};

    always_ff @(posedge clk)
    begin
        q_out_reg   <= {1'b0, q_reg[QB]} + (QB+1)'(round_up);
        ovf_out_reg <= ovf_reg[QB];
    end

    assign q   = q_out_reg;
    assign ovf = ovf_out_reg;

endmodule

### hw/rtl/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 Q16.16 matrix inverse by adjugate over determinant, fully pipelined
// ----------------------------------------------------------------------------
// The block takes one matrix word on every clock cycle: busy is always low,
// so a word is accepted whenever start is high. Each word comes back as one
// result word with done high for one cycle; there is no way to hold results
// off, so the receiver must take every done. The path is the divider, with
// 33 quotient bits, one per stage, plus its entry and rounding stages,
// behind six stages of products, cofactors and determinant and one output
// register. Write det_tolerance only while no word is in flight.
module matrix3_inverse
    import m3i_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             cfg_we,
    input  logic [TOL_W-1:0] cfg_wdata,
    input  elem_t            a_r0c0,
    input  elem_t            a_r0c1,
    input  elem_t            a_r0c2,
    input  elem_t            a_r1c0,
    input  elem_t            a_r1c1,
    input  elem_t            a_r1c2,
    input  elem_t            a_r2c0,
    input  elem_t            a_r2c1,
    input  elem_t            a_r2c2,
    output logic             done,
    output elem_t            inv_r0c0,
    output elem_t            inv_r0c1,
    output elem_t            inv_r0c2,
    output elem_t            inv_r1c0,
    output elem_t            inv_r1c1,
    output elem_t            inv_r1c2,
    output elem_t            inv_r2c0,
    output elem_t            inv_r2c1,
    output elem_t            inv_r2c2,
    output elem_t            determinant,
    output logic             invertible,
    output logic             saturated
);

    // everything the output stage needs besides the quotients
    typedef struct packed {
        logic                singular;
        logic [EW-1:0]       det_val;
        logic                det_clip;
        logic [8:0][EW-1:0]  adj_val;
        logic                adj_clip;
        logic [8:0]          qneg;
    } side_t;

    logic [TOL_W-1:0] tol_reg;

    elem_t      a_in [9];
    logic       s2_vld;
    cof_t       s2_p [9];
    elem_t      s2_row0 [3];
    logic       s6_vld;
    pmag_t      s6_pm [9];
    logic [8:0] s6_pneg;
    dmag_t      s6_dmag;
    logic       s6_dneg;

    side_t            side_next;
    side_t            side_reg [DIV_LAT];
    logic [DIV_LAT-1:0] vld_line_reg;
    logic [TW-1:0]    det_round;
    logic [AW-1:0]    adj_round [9];
    sat_t             det_s;
    sat_t             adj_s [9];

    logic [QB:0]      q_div [9];
    logic [8:0]       ovf_div;
    side_t            last;
    sat_t             qs [9];
    logic             div_clip;
    logic [8:0][EW-1:0] res_next;
    logic             clip_next;

    logic [8:0][EW-1:0] res_reg;
    elem_t            det_reg;
    logic             inv_ok_reg;
    logic             sat_reg;
    logic             done_reg;

    // every stage advances each cycle, nothing ever holds a word back
    assign busy = 1'b0;

    // tolerance register, takes all 31 bits of the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    assign a_in = '{a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                    a_r2c0, a_r2c1, a_r2c2};

    // stages 1-2: products and cofactors
    m3i_cofactor u_cof (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (start && !busy),
        .a       (a_in),
        .vld_out (s2_vld),
        .p       (s2_p),
        .row0    (s2_row0)
    );

    // stages 3-6: determinant by first-row expansion and its magnitude
    m3i_det u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (s2_vld),
        .p       (s2_p),
        .row0    (s2_row0),
        .vld_out (s6_vld),
        .pm      (s6_pm),
        .pneg    (s6_pneg),
        .dmag    (s6_dmag),
        .dneg    (s6_dneg)
    );

    // nine dividers run in lockstep with the side line
    for (genvar k = 0; k < 9; k++) begin : g_div
        m3i_divider u_div (
            .clk  (clk),
            .pm   (s6_pm[k]),
            .dmag (s6_dmag),
            .q    (q_div[k]),
            .ovf  (ovf_div[k])
        );
    end

    // singular test, rounded determinant and rounded adjugate, all exact
    always_comb
    begin
        det_round = TW'((s6_dmag + (DW'(1) << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS));
        det_s     = sat_q(SW'(det_round), s6_dneg);

        side_next.singular = s6_dmag <= (DW'(tol_reg) << (2*FRAC_BITS));
        side_next.det_val  = det_s.val;
        side_next.det_clip = det_s.clip;
        side_next.adj_clip = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            adj_round[k] = AW'(({1'b0, s6_pm[k]} + (PW+1)'(1 << (FRAC_BITS - 1)))
                               >> FRAC_BITS);
            adj_s[k]     = sat_q(SW'(adj_round[k]), s6_pneg[k]);
            side_next.adj_val[k] = adj_s[k].val;
            side_next.adj_clip   = side_next.adj_clip | adj_s[k].clip;
            side_next.qneg[k]    = s6_pneg[k] ^ s6_dneg;
        end
    end

    // side line, same depth as the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_line_reg <= '0;
        else
            vld_line_reg <= {vld_line_reg[DIV_LAT-2:0], s6_vld};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int s = 1; s < DIV_LAT; s++)
            side_reg[s] <= side_reg[s-1];
    end

    assign last = side_reg[DIV_LAT-1];

    // pick quotient or adjugate, saturate quotients
    always_comb
    begin
        div_clip = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            qs[k]    = sat_q(ovf_div[k] ? {SW{1'b1}} : SW'(q_div[k]), last.qneg[k]);
            div_clip = div_clip | qs[k].clip;
            res_next[k] = last.singular ? last.adj_val[k] : qs[k].val;
        end
        clip_next = last.det_clip | (last.singular ? last.adj_clip : div_clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_line_reg[DIV_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        det_reg    <= last.det_val;
        inv_ok_reg <= !last.singular;
        sat_reg    <= clip_next;
    end

    assign done        = done_reg;
    assign inv_r0c0    = res_reg[0];
    assign inv_r0c1    = res_reg[1];
    assign inv_r0c2    = res_reg[2];
    assign inv_r1c0    = res_reg[3];
    assign inv_r1c1    = res_reg[4];
    assign inv_r1c2    = res_reg[5];
    assign inv_r2c0    = res_reg[6];
    assign inv_r2c1    = res_reg[7];
    assign inv_r2c2    = res_reg[8];
    assign determinant = det_reg;
    assign invertible  = inv_ok_reg;
    assign saturated   = sat_reg;

    // every accepted word comes out after the full pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT done)
        else $error("accepted word did not come out on time");

    // a zero determinant must always be marked singular
    a_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
        (s6_vld && (s6_dmag == '0)) |=> side_reg[0].singular)
        else $error("zero determinant marked invertible");

    // reset empties the pipeline
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result strobe during reset");

endmodule
